@@ hw/rtl/kda_pkg.sv @@
// Shared types and constants for the keypad debounce and auto-repeat block.
package kda_pkg;

  localparam int unsigned KEY_W       = 8;
  localparam int unsigned PERIOD_W    = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned SLOW_CNT_W  = 3;

  localparam logic [SLOW_CNT_W-1:0] SLOW_REPEAT_COUNT = 3'd5;

  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 8'd10;
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 8'd3;
  localparam logic [KEY_W-1:0]    IDLE_CODE_RST   = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HREP_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VREP_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SLOW_PER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FAST_PER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IDLE_CODE = 3'd4;

  typedef enum logic [1:0] {
    KEY_CLASS_NONE   = 2'd0,
    KEY_CLASS_HORIZ  = 2'd1,
    KEY_CLASS_VERT   = 2'd2,
    KEY_CLASS_SINGLE = 2'd3
  } key_class_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic [1:0]       key_class;
    logic             read_error;
  } kda_in_t;

  typedef struct packed {
    logic             key_ready;
    logic [KEY_W-1:0] command_code;
    logic             escape_timer_clear;
  } kda_out_t;

  typedef struct packed {
    logic                horizontal_repeat_enable;
    logic                vertical_repeat_enable;
    logic [PERIOD_W-1:0] slow_repeat_period;
    logic [PERIOD_W-1:0] fast_repeat_period;
    logic [KEY_W-1:0]    idle_key_code;
  } kda_cfg_t;

endpackage

@@ hw/rtl/kda_cfg_regs.sv @@
// Configuration register file written through the plain write port.
module kda_cfg_regs
  import kda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output kda_cfg_t              cfg
);

  kda_cfg_t cfg_r;
  kda_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_HREP_EN:   cfg_nxt.horizontal_repeat_enable = cfg_wdata[0];
        CFG_IDX_VREP_EN:   cfg_nxt.vertical_repeat_enable   = cfg_wdata[0];
        CFG_IDX_SLOW_PER:  cfg_nxt.slow_repeat_period       = cfg_wdata[PERIOD_W-1:0];
        CFG_IDX_FAST_PER:  cfg_nxt.fast_repeat_period       = cfg_wdata[PERIOD_W-1:0];
        CFG_IDX_IDLE_CODE: cfg_nxt.idle_key_code            = cfg_wdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.horizontal_repeat_enable <= 1'b0;
      cfg_r.vertical_repeat_enable   <= 1'b0;
      cfg_r.slow_repeat_period       <= SLOW_PERIOD_RST;
      cfg_r.fast_repeat_period       <= FAST_PERIOD_RST;
      cfg_r.idle_key_code            <= IDLE_CODE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/kda_core.sv @@
// Debounce and auto-repeat state with the per-scan next-state logic.
module kda_core
  import kda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  kda_in_t  item,
  input  kda_cfg_t cfg,
  output kda_out_t res
);

  logic                  accept_enabled_r, accept_enabled_nxt;
  logic                  repeating_r, repeating_nxt;
  logic [KEY_W-1:0]      previous_key_r, previous_key_nxt;
  logic [PERIOD_W-1:0]   countdown_r, countdown_nxt;
  logic [SLOW_CNT_W-1:0] slow_left_r, slow_left_nxt;
  logic [KEY_W-1:0]      last_command_r, last_command_nxt;
  logic                  ready;
  logic                  esc;
  logic                  axis_en;

  always_comb begin
    accept_enabled_nxt = accept_enabled_r;
    repeating_nxt      = repeating_r;
    previous_key_nxt   = previous_key_r;
    countdown_nxt      = countdown_r;
    slow_left_nxt      = slow_left_r;
    last_command_nxt   = last_command_r;
    ready              = 1'b0;
    esc                = 1'b0;
    axis_en            = (item.key_class == KEY_CLASS_HORIZ) ?
                         cfg.horizontal_repeat_enable : cfg.vertical_repeat_enable;

    if (!item.read_error) begin
      if (accept_enabled_r) begin
        if (repeating_r) begin
          if (item.key_code == previous_key_r) begin
            if (countdown_r == '0) begin
              last_command_nxt = item.key_code;
              ready            = 1'b1;
              if (slow_left_r != '0) begin
                slow_left_nxt = slow_left_r - 1'b1;
                countdown_nxt = cfg.slow_repeat_period;
              end else begin
                countdown_nxt = cfg.fast_repeat_period;
              end
            end else begin
              countdown_nxt = countdown_r - 1'b1;
            end
          end else begin
            repeating_nxt = 1'b0;
          end
        end else if (item.key_code != cfg.idle_key_code) begin
          if (item.key_code == previous_key_r) begin
            esc = 1'b1;
            case (item.key_class)
              KEY_CLASS_HORIZ, KEY_CLASS_VERT: begin
                if (axis_en) begin
                  repeating_nxt = 1'b1;
                end else begin
                  accept_enabled_nxt = 1'b0;
                end
                slow_left_nxt    = SLOW_REPEAT_COUNT;
                countdown_nxt    = cfg.slow_repeat_period;
                last_command_nxt = item.key_code;
                ready            = 1'b1;
              end
              KEY_CLASS_SINGLE: begin
                accept_enabled_nxt = 1'b0;
                last_command_nxt   = item.key_code;
                ready              = 1'b1;
              end
              default: ;
            endcase
          end else begin
            previous_key_nxt = item.key_code;
          end
        end else begin
          previous_key_nxt = cfg.idle_key_code;
        end
      end else if (item.key_code == cfg.idle_key_code) begin
        accept_enabled_nxt = 1'b1;
        last_command_nxt   = cfg.idle_key_code;
        previous_key_nxt   = cfg.idle_key_code;
        repeating_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_enabled_r <= 1'b0;
      repeating_r      <= 1'b0;
      previous_key_r   <= '0;
      countdown_r      <= '0;
      slow_left_r      <= '0;
      last_command_r   <= '0;
    end else if (step_en) begin
      accept_enabled_r <= accept_enabled_nxt;
      repeating_r      <= repeating_nxt;
      previous_key_r   <= previous_key_nxt;
      countdown_r      <= countdown_nxt;
      slow_left_r      <= slow_left_nxt;
      last_command_r   <= last_command_nxt;
    end
  end

  assign res.key_ready          = ready;
  assign res.command_code       = last_command_nxt;
  assign res.escape_timer_clear = esc;

  a_ready_carries_code: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.key_ready |-> res.command_code == item.key_code)
    else $error("issued command differs from scanned key code");

  a_slow_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slow_left_r <= SLOW_REPEAT_COUNT)
    else $error("slow repeat count out of range");

  a_repeat_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    repeating_r |-> accept_enabled_r)
    else $error("repeating while acceptance is off");

endmodule

@@ hw/rtl/key_debounce_autorepeat.sv @@
// Keypad debounce and auto-repeat block: input register, scan logic, result register.
//
// Each input beat is one completed keypad scan (key code, key class, read
// error). Each scan produces exactly one result beat carrying key_ready,
// command_code and escape_timer_clear, in scan order.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. An accepted scan sits in the input register while the scan
// logic runs on it, and the result register loads the result when it is
// free to take a beat. One scan is accepted per cycle while the receiver
// does not stall; the rate is set by the single pass through the state
// update logic between the input and result registers.
// When the receiver stalls, the result register holds its beat and one
// further scan can still be taken into the input register before in_stall
// rises.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must do so only while no scan is in flight, which
// the block does not enforce. The synchronous reset empties both registers,
// waits for a key release and restores the register defaults.
module key_debounce_autorepeat
  import kda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kda_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output kda_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  kda_cfg_t cfg;
  kda_in_t  in_data_r;
  logic     in_valid_r;
  kda_out_t res;
  kda_out_t out_data_r;
  logic     out_valid_r;
  logic     out_free;
  logic     advance;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  kda_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kda_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_data_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("scan result lost after the scan logic ran");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the keypad debounce and auto-repeat block.
`timescale 1ns / 1ps

module testbench;
  import kda_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  kda_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  kda_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  key_debounce_autorepeat u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  kda_in_t  scan_queue[$];
  kda_out_t expected_results[$];

  kda_cfg_t         model_cfg;
  logic             kp_accept;
  logic             kp_repeating;
  logic [KEY_W-1:0] kp_prev_key;
  logic [PERIOD_W-1:0] kp_countdown;
  logic [SLOW_CNT_W-1:0] kp_slow_left;
  logic [KEY_W-1:0] kp_last_cmd;

  bit in_taken = 1'b0;
  bit pace_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int cycles = 0;
  int errors = 0;
  int n_scans = 0;
  int n_results = 0;
  int n_commands = 0;
  int n_clears = 0;
  int n_settings = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(5, 24);
  endfunction

  // One scan through the debounce and repeat logic; updates the scan state.
  task automatic debounce_scan(input kda_in_t scan, output kda_out_t res);
    key_class_t cls;
    logic       axis_en;
    cls = key_class_t'(scan.key_class);
    res = '0;
    if (!scan.read_error) begin
      if (kp_accept) begin
        if (kp_repeating) begin
          if (scan.key_code == kp_prev_key) begin
            if (kp_countdown == '0) begin
              kp_last_cmd = scan.key_code;
              if (kp_slow_left != '0) begin
                kp_slow_left = kp_slow_left - 1'b1;
                kp_countdown = model_cfg.slow_repeat_period;
              end else begin
                kp_countdown = model_cfg.fast_repeat_period;
              end
              res.key_ready = 1'b1;
            end else begin
              kp_countdown = kp_countdown - 1'b1;
            end
          end else begin
            kp_repeating = 1'b0;
          end
        end else if (scan.key_code != model_cfg.idle_key_code) begin
          if (scan.key_code == kp_prev_key) begin
            res.escape_timer_clear = 1'b1;
            case (cls)
              KEY_CLASS_HORIZ, KEY_CLASS_VERT: begin
                axis_en = (cls == KEY_CLASS_HORIZ) ? model_cfg.horizontal_repeat_enable
                                                   : model_cfg.vertical_repeat_enable;
                if (axis_en) kp_repeating = 1'b1;
                else kp_accept = 1'b0;
                kp_slow_left = SLOW_REPEAT_COUNT;
                kp_countdown = model_cfg.slow_repeat_period;
                kp_last_cmd = scan.key_code;
                res.key_ready = 1'b1;
              end
              KEY_CLASS_SINGLE: begin
                kp_accept = 1'b0;
                kp_last_cmd = scan.key_code;
                res.key_ready = 1'b1;
              end
              default: ;
            endcase
          end else begin
            kp_prev_key = scan.key_code;
          end
        end else begin
          kp_prev_key = model_cfg.idle_key_code;
        end
      end else if (scan.key_code == model_cfg.idle_key_code) begin
        kp_accept = 1'b1;
        kp_last_cmd = model_cfg.idle_key_code;
        kp_prev_key = model_cfg.idle_key_code;
        kp_repeating = 1'b0;
      end
    end
    res.command_code = kp_last_cmd;
  endtask

  // Scan sender.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (scan_queue.size() != 0) begin
        in_data <= scan_queue.pop_front();
        in_valid <= 1'b1;
        if (pace_on) gap_left = idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver back-pressure.
  always @(negedge clk) begin
    if (stall_left == 0 && pace_on) stall_left = idle_len();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on each accepted scan and checks each result beat.
  always @(posedge clk) begin
    kda_out_t res;
    kda_out_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
      model_cfg = '{1'b0, 1'b0, SLOW_PERIOD_RST, FAST_PERIOD_RST, IDLE_CODE_RST};
      kp_accept = 1'b0;
      kp_repeating = 1'b0;
      kp_prev_key = '0;
      kp_countdown = '0;
      kp_slow_left = '0;
      kp_last_cmd = '0;
    end else begin
      cycles++;
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        debounce_scan(in_data, res);
        expected_results.push_back(res);
        n_scans++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no scan pending: %p", out_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          n_results++;
          if (want.key_ready) n_commands++;
          if (want.escape_timer_clear) n_clears++;
          if (out_data.key_ready !== want.key_ready) begin
            $error("key_ready expected %0d actual %0d", want.key_ready, out_data.key_ready);
            errors++;
          end
          if (out_data.command_code !== want.command_code) begin
            $error("command_code expected 0x%02h actual 0x%02h",
                   want.command_code, out_data.command_code);
            errors++;
          end
          if (out_data.escape_timer_clear !== want.escape_timer_clear) begin
            $error("escape_timer_clear expected %0d actual %0d",
                   want.escape_timer_clear, out_data.escape_timer_clear);
            errors++;
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, expected_results.size());
        $display("testbench failed");
        $finish;
      end
    end
  end

  function automatic kda_in_t mk_scan(input logic [KEY_W-1:0] code, input key_class_t cls,
                                      input logic err);
    kda_in_t s;
    s.key_code = code;
    s.key_class = cls;
    s.read_error = err;
    return s;
  endfunction

  function automatic key_class_t any_class();
    return key_class_t'($urandom_range(0, 3));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] code;
    code = KEY_W'($urandom_range(0, 255));
    while (code == model_cfg.idle_key_code) code = KEY_W'($urandom_range(0, 255));
    return code;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IDX_HREP_EN:   model_cfg.horizontal_repeat_enable = val[0];
      CFG_IDX_VREP_EN:   model_cfg.vertical_repeat_enable = val[0];
      CFG_IDX_SLOW_PER:  model_cfg.slow_repeat_period = val;
      CFG_IDX_FAST_PER:  model_cfg.fast_repeat_period = val;
      CFG_IDX_IDLE_CODE: model_cfg.idle_key_code = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input kda_cfg_t s);
    write_reg(CFG_IDX_HREP_EN, CFG_DATA_W'(s.horizontal_repeat_enable));
    write_reg(CFG_IDX_VREP_EN, CFG_DATA_W'(s.vertical_repeat_enable));
    write_reg(CFG_IDX_SLOW_PER, s.slow_repeat_period);
    write_reg(CFG_IDX_FAST_PER, s.fast_repeat_period);
    write_reg(CFG_IDX_IDLE_CODE, s.idle_key_code);
    n_settings++;
  endtask

  task automatic drain();
    wait (scan_queue.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  // A press of one key held for a while, with the odd read error or stray
  // key mixed in, usually followed by a release.
  task automatic add_press(input int deep);
    logic [KEY_W-1:0] code;
    key_class_t       cls;
    int               hold;
    int               r;
    code = pick_key();
    cls = any_class();
    r = $urandom_range(0, 3);
    if (r == 0) hold = $urandom_range(1, 3);
    else if (r == 3) hold = $urandom_range(2, deep);
    else hold = $urandom_range(2, 12);
    for (int i = 0; i < hold; i++) begin
      if ($urandom_range(0, 15) == 0)
        scan_queue.push_back(mk_scan(KEY_W'($urandom_range(0, 255)), any_class(), 1'b1));
      if ($urandom_range(0, 39) == 0)
        scan_queue.push_back(mk_scan(pick_key(), any_class(), 1'b0));
      scan_queue.push_back(mk_scan(code, cls, 1'b0));
    end
    if ($urandom_range(0, 5) != 0) begin
      repeat ($urandom_range(1, 3))
        scan_queue.push_back(mk_scan(model_cfg.idle_key_code, any_class(), 1'b0));
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(2, 6))
      scan_queue.push_back(mk_scan(KEY_W'($urandom_range(0, 255)), any_class(),
                                   1'($urandom_range(0, 1))));
  endtask

  initial begin
    kda_cfg_t s;
    int       budget;
    int       deep;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: both axes without repeat.
    scan_queue.push_back(mk_scan(8'h00, KEY_CLASS_SINGLE, 1'b0));
    scan_queue.push_back(mk_scan(8'hFF, KEY_CLASS_NONE, 1'b1));
    scan_queue.push_back(mk_scan(8'hFF, KEY_CLASS_NONE, 1'b0));
    scan_queue.push_back(mk_scan(8'h00, KEY_CLASS_SINGLE, 1'b0));
    scan_queue.push_back(mk_scan(8'h00, KEY_CLASS_SINGLE, 1'b0));
    scan_queue.push_back(mk_scan(8'h00, KEY_CLASS_SINGLE, 1'b0));
    scan_queue.push_back(mk_scan(8'hFF, KEY_CLASS_HORIZ, 1'b0));
    scan_queue.push_back(mk_scan(8'h80, KEY_CLASS_HORIZ, 1'b0));
    scan_queue.push_back(mk_scan(8'h80, KEY_CLASS_HORIZ, 1'b0));
    scan_queue.push_back(mk_scan(8'h80, KEY_CLASS_HORIZ, 1'b0));
    scan_queue.push_back(mk_scan(8'hFF, KEY_CLASS_VERT, 1'b0));
    scan_queue.push_back(mk_scan(8'h7E, KEY_CLASS_NONE, 1'b0));
    scan_queue.push_back(mk_scan(8'h7E, KEY_CLASS_NONE, 1'b0));
    scan_queue.push_back(mk_scan(8'h7E, KEY_CLASS_NONE, 1'b0));
    scan_queue.push_back(mk_scan(8'hFF, KEY_CLASS_NONE, 1'b0));
    scan_queue.push_back(mk_scan(8'h01, KEY_CLASS_VERT, 1'b0));
    scan_queue.push_back(mk_scan(8'h01, KEY_CLASS_VERT, 1'b0));
    scan_queue.push_back(mk_scan(8'hFF, KEY_CLASS_SINGLE, 1'b1));
    scan_queue.push_back(mk_scan(8'hFF, KEY_CLASS_SINGLE, 1'b0));
    drain();

    // Repeat on every scan, then a key change in the middle of repeating.
    apply_settings('{1'b1, 1'b1, 8'd0, 8'd0, 8'hFF});
    scan_queue.push_back(mk_scan(8'hFF, KEY_CLASS_NONE, 1'b0));
    repeat (9) scan_queue.push_back(mk_scan(8'hAA, KEY_CLASS_HORIZ, 1'b0));
    repeat (3) scan_queue.push_back(mk_scan(8'h55, KEY_CLASS_HORIZ, 1'b0));
    scan_queue.push_back(mk_scan(8'hFF, KEY_CLASS_NONE, 1'b0));
    drain();

    for (int p = 0; p < 8; p++) begin
      budget = 150;
      pace_on = 1'b1;
      case (p)
        0: s = '{1'b1, 1'b1, 8'd0, 8'd0, 8'h00};
        1: s = '{1'b1, 1'b0, 8'd1, 8'd2, 8'hFF};
        2: begin
          s = '{1'b0, 1'b1, 8'd2, 8'd0, 8'($urandom_range(0, 255))};
          pace_on = 1'b0;
        end
        3: begin
          s = '{1'b1, 1'b1, 8'd255, 8'd255, 8'($urandom_range(0, 255))};
          budget = 500;
        end
        4: s = '{1'b1, 1'b1, 8'd3, 8'd1, 8'($urandom_range(0, 255))};
        5: begin
          s = '{1'b0, 1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'hFF};
          pace_on = 1'b0;
        end
        6: s = '{1'b1, 1'b1, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255))};
        default: s = '{1'b1, 1'b1, 8'd0, 8'd255, 8'($urandom_range(0, 255))};
      endcase
      apply_settings(s);
      deep = 8 * (s.slow_repeat_period + 1) + 4 * (s.fast_repeat_period + 1);
      if (deep > 600) deep = 600;
      scan_queue.push_back(mk_scan(model_cfg.idle_key_code, any_class(), 1'b0));
      while (scan_queue.size() < budget) begin
        if ($urandom_range(0, 7) == 0) add_noise();
        else add_press(deep);
      end
      drain();
    end

    pace_on = 1'b1;
    repeat (10) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("Checked %0d results from %0d scans under %0d register settings.",
             n_results, n_scans, n_settings + 1);
    $display("Seen %0d key commands and %0d escape timer clears; %0d mismatches.",
             n_commands, n_clears, errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
